### rtl/flp_pkg.sv
// Shared types and constants for the floppy sector ID search block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package flp_pkg;

    // Default table depth, handed to the top-level parameter.
    localparam int MAX_SECTORS_DEF = 32;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_TRACK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_FORMAT   = 1'b1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_DATA_W-1:0] SPT_RESET = 6'd9;

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    // ID flag masks and the base size for the size code.
    localparam logic [7:0]  SKIP_MASK      = 8'h05;
    localparam logic [7:0]  DELETED_MASK   = 8'h80;
    localparam logic [7:0]  SIZE_CODE_MASK = 8'h07;
    localparam logic [15:0] BASE_SIZE      = 16'd128;

    localparam int OFFSET_W = 21;
    localparam int ENTRY_W  = 64;

    // One input request.
    typedef struct packed {
        logic        mode;
        logic [4:0]  entry_index;
        logic [7:0]  id_cylinder;
        logic [7:0]  id_head;
        logic [7:0]  id_record;
        logic [7:0]  id_size_code;
        logic [7:0]  status_one;
        logic [7:0]  status_two;
        logic [15:0] byte_count;
        logic        want_deleted;
        logic        any_sector;
    } t_req;

    // One search result.
    typedef struct packed {
        logic                found;
        logic [7:0]          out_cylinder;
        logic [7:0]          out_head;
        logic [7:0]          out_record;
        logic [7:0]          out_size_code;
        logic [7:0]          out_status_one;
        logic [7:0]          out_status_two;
        logic [OFFSET_W-1:0] data_offset;
        logic [15:0]         data_size;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } t_stat;

endpackage

### rtl/flp_req_if.sv
// Request channel of the sector ID search: valid, ready and one request.
// Depends on flp_pkg.
interface flp_req_if import flp_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/flp_res_if.sv
// Result channel of the sector ID search: valid, ready and one result.
// Depends on flp_pkg.
interface flp_res_if import flp_pkg::*; ();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/floppy_sector_id_search.sv
// Floppy sector ID search: a load request writes one table entry; a find runs
// the scan that reads one RAM entry per cycle over up to two revolutions of
// the track, and an empty track ends the find without a scan.
// The output register lets the next request in while a result waits.
// Synchronous active-low reset clears control state and configuration; the
// entry RAM holds no defined contents until loaded.
module floppy_sector_id_search import flp_pkg::*; #(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    flp_req_if.sink               i_req,
    flp_res_if.source             o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;

    flp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .i_req_mode (i_req.payload.mode),
        .o_req_ready(i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    flp_dp #(
        .MAX_SECTORS(MAX_SECTORS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req.payload),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_out_ready(o_res.ready),
        .o_out_valid(o_res.valid),
        .o_out      (o_res.payload)
    );

    // A load and a search never start in the same cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.start))
        else $error("load and start issued together");

    // A result is only published into a free output register.
    a_pub_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> w_stat.out_free)
        else $error("publish into an occupied output register");

    // A published result is presented on the next cycle.
    a_pub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |=> o_res.valid)
        else $error("published result not presented");

    // No new request is taken while a search runs.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> !i_req.ready)
        else $error("request taken during a search");

endmodule

### rtl/flp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module flp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/flp_ctrl.sv
// Controller of the sector ID search: accepts requests, runs a search to its
// end and hands the result to the output register. Depends on flp_pkg.
module flp_ctrl import flp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  logic  i_req_mode,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   w_accept;

    assign w_accept = i_req_valid && r_ready;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_ready       = r_ready;
        o_cmd.load    = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.publish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_mode == MODE_FIND) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                        n_ready     = 1'b0;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                // Wait until the output register can take the result.
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                    n_ready       = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;

endmodule

### rtl/flp_dp.sv
// Datapath of the sector ID search: configuration registers, the entry RAM,
// the scan pipeline with offset accumulation, and the output register.
// Depends on flp_pkg and flp_ram.
module flp_dp import flp_pkg::*; #(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_res                  o_out
);

    localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTORS + 1);

    // Control registers.
    logic [CFG_DATA_W-1:0] r_spt_cfg;
    logic                  r_ext;
    logic [IDX_W-1:0]      r_pos;
    logic                  r_rd_live;
    logic                  r_d_valid;
    logic                  r_done;
    logic                  r_out_valid;

    // Scan payload registers.
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_rd_pass;
    logic [IDX_W-1:0]    r_d_idx;
    logic                r_d_pass;
    logic [IDX_W-1:0]    r_pos0;
    logic [OFFSET_W-1:0] r_offset;
    t_req                r_key;
    t_res                r_res;
    t_res                r_out;

    logic [CNT_W-1:0]   w_spt;
    logic [CNT_W-1:0]   w_spt_m1;
    logic [IDX_W-1:0]   w_start_pos;
    logic               w_load_ok;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [15:0]        w_load_size;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_rd_last;
    logic               w_d_last;
    logic               w_active;
    logic               w_readable;
    logic               w_id_match;
    logic               w_hit;
    logic               w_miss_end;
    logic [IDX_W-1:0]   w_next_pos;

    // Effective track length, clamped to the table depth.
    assign w_spt = ({1'b0, r_spt_cfg} > 7'(MAX_SECTORS)) ? CNT_W'(MAX_SECTORS)
                                                          : CNT_W'(r_spt_cfg);
    assign w_spt_m1 = w_spt - CNT_W'(1);
    assign w_start_pos = (CNT_W'(r_pos) >= w_spt) ? '0 : r_pos;

    // Load path: entry packing and size selection.
    assign w_load_ok = (int'(i_req.entry_index) < MAX_SECTORS);
    assign w_waddr   = IDX_W'(i_req.entry_index);
    assign w_load_size = r_ext ? i_req.byte_count
        : 16'(BASE_SIZE << (i_req.id_size_code & SIZE_CODE_MASK));
    assign w_wdata = {w_load_size, i_req.status_two, i_req.status_one,
                      i_req.id_size_code, i_req.id_record, i_req.id_head,
                      i_req.id_cylinder};

    flp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SECTORS),
        .ADDR_W(IDX_W)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && w_load_ok),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_idx),
        .o_rdata(w_rdata)
    );

    // Evaluation of the entry that the RAM returns this cycle.
    assign w_rd_last  = (CNT_W'(r_rd_idx) == w_spt_m1);
    assign w_d_last   = (CNT_W'(r_d_idx) == w_spt_m1);
    assign w_active   = r_d_pass || (r_d_idx >= r_pos0);
    assign w_readable = ((w_rdata[39:32] & SKIP_MASK) == 8'h00);
    assign w_id_match = (((w_rdata[47:40] & DELETED_MASK) != 8'h00) == r_key.want_deleted)
                        && (w_rdata[7:0]   == r_key.id_cylinder)
                        && (w_rdata[15:8]  == r_key.id_head)
                        && (w_rdata[23:16] == r_key.id_record)
                        && (w_rdata[31:24] == r_key.id_size_code);
    assign w_hit      = r_d_valid && w_active && w_readable
                        && (r_key.any_sector || w_id_match);
    assign w_miss_end = r_d_valid && !w_hit && w_d_last && r_d_pass;
    assign w_next_pos = w_d_last ? '0 : IDX_W'(r_d_idx + IDX_W'(1));

    // Control state: configuration, position, pipeline valids, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt_cfg   <= SPT_RESET;
            r_ext       <= 1'b0;
            r_pos       <= '0;
            r_rd_live   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SECTORS_PER_TRACK: r_spt_cfg <= i_cfg_data;
                    CFG_EXTENDED_FORMAT:   r_ext     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_done <= 1'b0;
            if (i_cmd.load && w_load_ok) begin
                r_pos <= '0;
            end
            if (i_cmd.start) begin
                r_d_valid <= 1'b0;
                if (w_spt == '0) begin
                    r_done <= 1'b1;
                    r_pos  <= '0;
                end else begin
                    r_rd_live <= 1'b1;
                end
            end else begin
                r_d_valid <= r_rd_live;
                if (r_rd_live && w_rd_last && r_rd_pass) begin
                    r_rd_live <= 1'b0;
                end
                // A hit or the end of the second pass ends the search.
                if (w_hit || w_miss_end) begin
                    r_rd_live <= 1'b0;
                    r_d_valid <= 1'b0;
                    r_done    <= 1'b1;
                    r_pos     <= w_hit ? w_next_pos : '0;
                end
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan counters, offset accumulation and result capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rd_idx  <= '0;
            r_rd_pass <= 1'b0;
            r_offset  <= '0;
            r_pos0    <= w_start_pos;
            r_key     <= i_req;
            r_res     <= '0;
        end else begin
            if (r_rd_live) begin
                r_rd_idx <= w_rd_last ? '0 : IDX_W'(r_rd_idx + IDX_W'(1));
                if (w_rd_last) begin
                    r_rd_pass <= 1'b1;
                end
            end
            if (r_d_valid) begin
                r_offset <= w_d_last ? '0 : r_offset + OFFSET_W'(w_rdata[63:48]);
            end
            if (w_hit) begin
                r_res.found          <= 1'b1;
                r_res.out_cylinder   <= w_rdata[7:0];
                r_res.out_head       <= w_rdata[15:8];
                r_res.out_record     <= w_rdata[23:16];
                r_res.out_size_code  <= w_rdata[31:24];
                r_res.out_status_one <= w_rdata[39:32];
                r_res.out_status_two <= w_rdata[47:40];
                r_res.data_offset    <= r_offset;
                r_res.data_size      <= w_rdata[63:48];
            end
        end
        r_d_idx  <= r_rd_idx;
        r_d_pass <= r_rd_pass;
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule
